// File: rtl/core/nvpk_pkg.sv
// Shared types and constants for the name-value pair key lookup block.
package nvpk_pkg;

  localparam int unsigned MAX_KEY_BYTES = 32;
  localparam int unsigned STREAM_BYTES  = 65536;

  // Largest byte offset that is reported
  localparam int unsigned POS_MAX_INT =
    ((STREAM_BYTES - 1) > 65535) ? 65535 : (STREAM_BYTES - 1);
  localparam logic [16:0] POS_MAX = 17'(POS_MAX_INT);

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [2:0] REG_KEY_BYTES_A = 3'd1;
  localparam logic [2:0] REG_KEY_BYTES_B = 3'd2;
  localparam logic [2:0] REG_KEY_BYTES_C = 3'd3;
  localparam logic [2:0] REG_KEY_BYTES_D = 3'd4;

  typedef struct packed {
    logic [5:0]       key_length;
    logic [31:0][7:0] key_bytes;
  } key_cfg_t;

endpackage

// File: rtl/core/nvpk_if.sv
// Valid/ready channel interfaces for the stream input and the lookup result.
interface nvpk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface nvpk_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] value_offset;
  logic [30:0] value_length;

  modport source (output valid, output found, output value_offset, output value_length,
                  input ready);
  modport sink (input valid, input found, input value_offset, input value_length,
                output ready);
endinterface

// File: rtl/core/nvpk_parse.sv
// Pair parser: input register, parse step that updates the parser state, result register.
module nvpk_parse (
  input  logic               clk,
  input  logic               rst,
  input  nvpk_pkg::key_cfg_t cfg,
  nvpk_in_if.sink            stream_in,
  nvpk_out_if.source         result_out
);

  localparam logic [2:0] PH_NAME_LEN  = 3'd0;
  localparam logic [2:0] PH_VALUE_LEN = 3'd1;
  localparam logic [2:0] PH_NAME      = 3'd2;
  localparam logic [2:0] PH_SKIP      = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  // Input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Parse state
  logic [2:0]  phase, phase_next;
  logic [1:0]  lbc, lbc_next;
  logic [30:0] name_len, name_len_next;
  logic [30:0] value_len, value_len_next;
  logic [4:0]  cidx, cidx_next;
  logic        mis, mis_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [15:0] pos, pos_next;

  // Result register
  logic        out_valid;
  logic        out_found;
  logic [15:0] out_offset;
  logic [30:0] out_length;

  logic        adv;
  logic        emit;
  logic        emit_found;
  logic [15:0] emit_offset;
  logic [30:0] emit_length;

  logic [16:0] pos_inc;
  logic [15:0] pos_sat;
  logic [30:0] len_src;
  logic [30:0] len_new;
  logic        len_done;
  logic        key_fit;
  logic        mis_now;
  logic [31:0] pair_sum;

  assign adv             = !out_valid || result_out.ready;
  assign stream_in.ready = !s1_valid || adv;

  assign pos_inc = {1'b0, pos} + 17'd1;
  assign pos_sat = (pos_inc > nvpk_pkg::POS_MAX) ? nvpk_pkg::POS_MAX[15:0] : pos_inc[15:0];

  // Shared length accumulator for the name and value lengths
  assign len_src = (phase == PH_VALUE_LEN) ? value_len : name_len;
  always_comb begin
    if (lbc == 2'd0) begin
      if (s1_byte[7]) begin
        len_new  = {24'd0, s1_byte[6:0]};
        len_done = 1'b0;
      end else begin
        len_new  = {23'd0, s1_byte};
        len_done = 1'b1;
      end
    end else begin
      len_new  = {len_src[22:0], s1_byte};
      len_done = (lbc == 2'd1);
    end
  end

  assign key_fit  = (name_len == {25'd0, cfg.key_length}) &&
                    ({26'd0, cfg.key_length} <= 32'(nvpk_pkg::MAX_KEY_BYTES));
  assign mis_now  = mis || (s1_byte != cfg.key_bytes[cidx]);
  assign pair_sum = {1'b0, name_len} + {1'b0, len_new};

  always_comb begin
    phase_next     = phase;
    lbc_next       = lbc;
    name_len_next  = name_len;
    value_len_next = value_len;
    cidx_next      = cidx;
    mis_next       = mis;
    skip_rem_next  = skip_rem;
    pos_next       = pos;
    emit           = 1'b0;
    emit_found     = 1'b0;
    emit_offset    = '0;
    emit_length    = '0;

    unique case (phase)
      PH_NAME_LEN: begin
        name_len_next = len_new;
        lbc_next      = (lbc == 2'd0) ? (s1_byte[7] ? 2'd3 : 2'd0) : lbc - 2'd1;
        if (len_done) begin
          phase_next = PH_VALUE_LEN;
        end
      end
      PH_VALUE_LEN: begin
        value_len_next = len_new;
        lbc_next       = (lbc == 2'd0) ? (s1_byte[7] ? 2'd3 : 2'd0) : lbc - 2'd1;
        if (len_done) begin
          if (key_fit) begin
            if (name_len == 31'd0) begin
              emit        = 1'b1;
              emit_found  = 1'b1;
              emit_offset = pos_sat;
              emit_length = len_new;
              phase_next  = PH_DONE;
            end else begin
              phase_next = PH_NAME;
              cidx_next  = '0;
              mis_next   = 1'b0;
            end
          end else begin
            skip_rem_next = pair_sum;
            phase_next    = (pair_sum != 32'd0) ? PH_SKIP : PH_NAME_LEN;
          end
        end
      end
      PH_NAME: begin
        mis_next = mis_now;
        if (({26'd0, cidx} + 32'd1) >= {1'b0, name_len}) begin
          if (!mis_now) begin
            emit        = 1'b1;
            emit_found  = 1'b1;
            emit_offset = pos_sat;
            emit_length = value_len;
            phase_next  = PH_DONE;
          end else begin
            skip_rem_next = {1'b0, value_len};
            phase_next    = (value_len != 31'd0) ? PH_SKIP : PH_NAME_LEN;
          end
        end else begin
          cidx_next = cidx + 5'd1;
        end
      end
      PH_SKIP: begin
        skip_rem_next = skip_rem - 32'd1;
        if (skip_rem == 32'd1) begin
          phase_next = PH_NAME_LEN;
        end
      end
      default: begin
      end
    endcase

    if (s1_last) begin
      // Report not-found unless this stream already matched
      if (!emit && phase_next != PH_DONE) begin
        emit        = 1'b1;
        emit_found  = 1'b0;
        emit_offset = '0;
        emit_length = '0;
      end
      phase_next     = PH_NAME_LEN;
      lbc_next       = '0;
      name_len_next  = '0;
      value_len_next = '0;
      cidx_next      = '0;
      mis_next       = 1'b0;
      skip_rem_next  = '0;
      pos_next       = '0;
    end else begin
      pos_next = pos_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream_in.valid && stream_in.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (stream_in.valid && stream_in.ready) begin
      s1_byte <= stream_in.stream_byte;
      s1_last <= stream_in.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NAME_LEN;
      lbc       <= '0;
      name_len  <= '0;
      value_len <= '0;
      cidx      <= '0;
      mis       <= 1'b0;
      skip_rem  <= '0;
      pos       <= '0;
    end else if (s1_valid && adv) begin
      phase     <= phase_next;
      lbc       <= lbc_next;
      name_len  <= name_len_next;
      value_len <= value_len_next;
      cidx      <= cidx_next;
      mis       <= mis_next;
      skip_rem  <= skip_rem_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && emit;
    end
    if (adv && s1_valid && emit) begin
      out_found  <= emit_found;
      out_offset <= emit_offset;
      out_length <= emit_length;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.found        = out_found;
  assign result_out.value_offset = out_offset;
  assign result_out.value_length = out_length;

endmodule

// File: rtl/core/name_value_pair_key_lookup.sv
// Name-value pair key lookup: takes one stream byte per clock and reports
// whether a pair with the configured name is present, with its value offset and
// length. A byte is registered on entry, then the pair parser state advances
// and any result lands in an output register. One byte is accepted every
// cycle; the input side holds only while a result waits in the output register
// and the sink is not ready. Key registers are written through the APB port at
// byte address 8*index and should be changed only while the block is idle.
module name_value_pair_key_lookup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nvpk_pkg::ADDR_W-1:0]     paddr,
  input  logic [nvpk_pkg::DATA_W-1:0]     pwdata,
  output logic [nvpk_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  nvpk_in_if.sink                         stream_in,
  nvpk_out_if.source                      result_out
);

  logic [5:0]  key_length;
  logic [63:0] key_bytes_a;
  logic [63:0] key_bytes_b;
  logic [63:0] key_bytes_c;
  logic [63:0] key_bytes_d;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  nvpk_pkg::key_cfg_t cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= '0;
      key_bytes_a <= '0;
      key_bytes_b <= '0;
      key_bytes_c <= '0;
      key_bytes_d <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        nvpk_pkg::REG_KEY_LENGTH:  key_length  <= pwdata[5:0];
        nvpk_pkg::REG_KEY_BYTES_A: key_bytes_a <= pwdata;
        nvpk_pkg::REG_KEY_BYTES_B: key_bytes_b <= pwdata;
        nvpk_pkg::REG_KEY_BYTES_C: key_bytes_c <= pwdata;
        nvpk_pkg::REG_KEY_BYTES_D: key_bytes_d <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nvpk_pkg::REG_KEY_LENGTH:  prdata = {58'd0, key_length};
      nvpk_pkg::REG_KEY_BYTES_A: prdata = key_bytes_a;
      nvpk_pkg::REG_KEY_BYTES_B: prdata = key_bytes_b;
      nvpk_pkg::REG_KEY_BYTES_C: prdata = key_bytes_c;
      nvpk_pkg::REG_KEY_BYTES_D: prdata = key_bytes_d;
      default:                   prdata = '0;
    endcase
  end

  assign cfg.key_length = key_length;
  assign cfg.key_bytes  = {key_bytes_d, key_bytes_c, key_bytes_b, key_bytes_a};

  nvpk_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stream_in  (stream_in),
    .result_out (result_out)
  );

endmodule

// File: verif/name_value_pair_key_lookup_test.sv
`timescale 1ns / 1ps
// Self-checking test of the name-value pair key lookup block against a local parser model.
module name_value_pair_key_lookup_test;

  typedef enum logic [2:0] {
    PARSE_NAME_LEN,
    PARSE_VALUE_LEN,
    PARSE_NAME,
    PARSE_SKIP,
    PARSE_DONE
  } parse_state_t;

  typedef struct packed {
    logic        found;
    logic [15:0] value_offset;
    logic [30:0] value_length;
  } lookup_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned ROUND_BYTES = 30;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [nvpk_pkg::ADDR_W-1:0] paddr;
  logic [nvpk_pkg::DATA_W-1:0] pwdata;
  logic [nvpk_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  nvpk_in_if  stream_if ();
  nvpk_out_if result_if ();

  name_value_pair_key_lookup dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .stream_in  (stream_if),
    .result_out (result_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser model state and its copy of the key registers
  parse_state_t       parse_state  = PARSE_NAME_LEN;
  logic [1:0]         len_left     = '0;
  logic [30:0]        name_len     = '0;
  logic [30:0]        value_len    = '0;
  logic [4:0]         cmp_idx      = '0;
  logic               name_differs = 1'b0;
  logic [31:0]        skip_left    = '0;
  logic [15:0]        byte_pos     = '0;
  nvpk_pkg::key_cfg_t key_cfg      = '0;

  lookup_t      expected_lookups [$];
  logic [7:0]   stream_buf [$];

  int unsigned  cycle_count   = 0;
  int unsigned  bytes_sent    = 0;
  int           mismatch_count = 0;
  int           hold_left     = 0;
  bit           gaps_on       = 1'b1;

  function automatic void clear_parse();
    parse_state  = PARSE_NAME_LEN;
    len_left     = '0;
    name_len     = '0;
    value_len    = '0;
    cmp_idx      = '0;
    name_differs = 1'b0;
    skip_left    = '0;
    byte_pos     = '0;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] p);
    if (17'(p) + 17'd1 > nvpk_pkg::POS_MAX) return nvpk_pkg::POS_MAX[15:0];
    return p + 16'd1;
  endfunction

  // Fold one length byte into the name or value length; 1 when the length is complete.
  function automatic logic take_len(input logic is_value, input logic [7:0] b);
    logic [31:0] acc;
    logic        done;
    acc  = is_value ? 32'(value_len) : 32'(name_len);
    done = 1'b0;
    if (len_left == 2'd0) begin
      if (b[7]) begin
        acc      = 32'(b[6:0]);
        len_left = 2'd3;
      end else begin
        acc  = 32'(b);
        done = 1'b1;
      end
    end else begin
      acc      = ((acc << 8) | 32'(b)) & 32'h7fff_ffff;
      len_left = len_left - 2'd1;
      done     = (len_left == 2'd0);
    end
    if (is_value) value_len = acc[30:0];
    else name_len = acc[30:0];
    return done;
  endfunction

  function automatic void start_skip(input logic [31:0] count);
    skip_left = count;
    if (count != 0) parse_state = PARSE_SKIP;
    else parse_state = PARSE_NAME_LEN;
  endfunction

  function automatic lookup_t found_at(input logic [15:0] pos);
    parse_state = PARSE_DONE;
    return '{found: 1'b1, value_offset: sat_inc(pos), value_length: value_len};
  endfunction

  function automatic void predict_lookup(input logic [7:0] b, input logic last);
    lookup_t     r;
    logic        emit;
    logic [15:0] pos;
    r    = '0;
    emit = 1'b0;
    pos  = byte_pos;
    case (parse_state)
      PARSE_NAME_LEN: begin
        if (take_len(1'b0, b)) parse_state = PARSE_VALUE_LEN;
      end
      PARSE_VALUE_LEN: begin
        if (take_len(1'b1, b)) begin
          if (31'(key_cfg.key_length) == name_len &&
              key_cfg.key_length <= nvpk_pkg::MAX_KEY_BYTES) begin
            if (name_len == 0) begin
              r    = found_at(pos);
              emit = 1'b1;
            end else begin
              parse_state  = PARSE_NAME;
              cmp_idx      = '0;
              name_differs = 1'b0;
            end
          end else begin
            start_skip(32'(name_len) + 32'(value_len));
          end
        end
      end
      PARSE_NAME: begin
        if (b != key_cfg.key_bytes[cmp_idx]) name_differs = 1'b1;
        if (32'(cmp_idx) + 32'd1 >= 32'(name_len)) begin
          if (!name_differs) begin
            r    = found_at(pos);
            emit = 1'b1;
          end else begin
            start_skip(32'(value_len));
          end
        end else begin
          cmp_idx = cmp_idx + 5'd1;
        end
      end
      PARSE_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) parse_state = PARSE_NAME_LEN;
      end
      default: ;
    endcase
    if (last) begin
      // not-found only when nothing matched in this stream
      if (!emit && parse_state != PARSE_DONE) emit = 1'b1;
      clear_parse();
    end else begin
      byte_pos = sat_inc(pos);
    end
    if (emit) expected_lookups.push_back(r);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) note_mismatch($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
  endfunction

  always @(posedge clk) begin : check_results
    lookup_t want;
    lookup_t got;
    if (!rst) begin
      if (stream_if.valid && stream_if.ready)
        predict_lookup(stream_if.stream_byte, stream_if.final_byte);
      if (result_if.valid && result_if.ready) begin
        got = {result_if.found, result_if.value_offset, result_if.value_length};
        if (expected_lookups.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0b offset=%0d length=%0d",
                                  got.found, got.value_offset, got.value_length));
        end else begin
          want = expected_lookups.pop_front();
          check_field("found", 64'(want.found), 64'(got.found));
          check_field("value_offset", 64'(want.value_offset), 64'(got.value_offset));
          check_field("value_length", 64'(want.value_length), 64'(got.value_length));
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_if.ready <= !(gaps_on && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] data);
    logic [63:0] want;
    want = (idx == nvpk_pkg::REG_KEY_LENGTH) ? 64'(data[5:0]) : data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      nvpk_pkg::REG_KEY_LENGTH:  key_cfg.key_length       = data[5:0];
      nvpk_pkg::REG_KEY_BYTES_A: key_cfg.key_bytes[7:0]   = data;
      nvpk_pkg::REG_KEY_BYTES_B: key_cfg.key_bytes[15:8]  = data;
      nvpk_pkg::REG_KEY_BYTES_C: key_cfg.key_bytes[23:16] = data;
      nvpk_pkg::REG_KEY_BYTES_D: key_cfg.key_bytes[31:24] = data;
      default: ;
    endcase
    // read back through a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field($sformatf("register %0d readback", idx), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [5:0] len, input logic [31:0][7:0] kb);
    apb_write(nvpk_pkg::REG_KEY_LENGTH, 64'(len));
    apb_write(nvpk_pkg::REG_KEY_BYTES_A, kb[7:0]);
    apb_write(nvpk_pkg::REG_KEY_BYTES_B, kb[15:8]);
    apb_write(nvpk_pkg::REG_KEY_BYTES_C, kb[23:16]);
    apb_write(nvpk_pkg::REG_KEY_BYTES_D, kb[31:24]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gaps_on && $urandom_range(99) < 17) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    stream_if.final_byte  <= last;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the buffered bytes; close marks the last one as the end of the stream.
  task automatic send_stream(input logic close = 1'b1);
    foreach (stream_buf[i]) send_byte(stream_buf[i], close && (i == stream_buf.size() - 1));
    stream_buf.delete();
  endtask

  task automatic drain();
    stream_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
    // let trailing bytes with no result leave the pipeline
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0][7:0] random_key();
    logic [31:0][7:0] k;
    for (int i = 0; i < 32; i++) k[i] = 8'($urandom);
    return k;
  endfunction

  function automatic void add_len(input int unsigned len, input logic long_form);
    logic [30:0] l;
    l = 31'(len);
    if (!long_form && l < 31'd128) begin
      stream_buf.push_back(l[7:0]);
    end else begin
      stream_buf.push_back({1'b1, l[30:24]});
      stream_buf.push_back(l[23:16]);
      stream_buf.push_back(l[15:8]);
      stream_buf.push_back(l[7:0]);
    end
  endfunction

  function automatic void add_random(input int unsigned n);
    repeat (n) stream_buf.push_back(8'($urandom));
  endfunction

  // Name built from the key; invert the byte at flip_at to force a miss.
  function automatic void add_key_name(input int unsigned n, input int flip_at);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = (i < 32) ? key_cfg.key_bytes[i] : 8'($urandom);
      if (i == flip_at) b = ~b;
      stream_buf.push_back(b);
    end
  endfunction

  function automatic void build_random_stream();
    int unsigned klen;
    int unsigned nlen;
    int unsigned vlen;
    int unsigned kind;
    int unsigned cut;
    klen = key_cfg.key_length;
    stream_buf.delete();
    if ($urandom_range(9) == 0) begin
      add_random($urandom_range(1, 12));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(9);
      vlen = $urandom_range(0, 6);
      nlen = klen;
      if (kind == 6 || kind == 7) nlen = $urandom_range(0, 40);
      if (kind == 8) nlen = 0;
      if (kind == 9) vlen = $urandom_range(32'h7fff_ffff);
      add_len(nlen, $urandom_range(3) == 0);
      add_len(vlen, $urandom_range(3) == 0);
      if (kind == 6 || kind == 7) add_random(nlen);
      else if (kind == 4 || kind == 5) add_key_name(nlen, (nlen > 0) ? $urandom_range(nlen - 1) : -1);
      else add_key_name(nlen, -1);
      add_random((vlen > 6) ? 3 : vlen);
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, stream_buf.size() - 1);
      while (stream_buf.size() > cut) void'(stream_buf.pop_back());
    end
  endfunction

  task automatic test_empty_key();
    load_key(6'd0, '0);
    add_len(0, 1'b0);
    add_len(3, 1'b0);
    add_random(3);
    send_stream();
    // other-length pair skipped, then an empty name matching on the last byte
    add_len(2, 1'b0);
    add_len(1, 1'b0);
    add_random(3);
    add_len(0, 1'b1);
    add_len(0, 1'b1);
    send_stream();
    drain();
  endtask

  task automatic test_short_key();
    logic [31:0][7:0] kb;
    kb    = random_key();
    kb[0] = 8'h00;
    kb[1] = 8'hff;
    kb[2] = 8'h41;
    load_key(6'd3, kb);
    add_len(3, 1'b0);
    add_len(2, 1'b0);
    add_key_name(3, -1);
    add_random(2);
    send_stream();
    add_len(3, 1'b0);
    add_len(1, 1'b0);
    add_key_name(3, 2);
    add_random(1);
    add_len(3, 1'b0);
    add_len(0, 1'b0);
    add_key_name(3, -1);
    send_stream();
    add_len(5, 1'b0);
    add_len(1, 1'b0);
    add_random(6);
    add_len(3, 1'b1);
    add_len(1, 1'b0);
    add_key_name(3, -1);
    add_random(1);
    send_stream();
    // truncated pairs
    add_len(3, 1'b0);
    add_len(4, 1'b0);
    add_key_name(2, -1);
    send_stream();
    stream_buf.push_back(8'h83);
    send_stream();
    add_len(31'h7fff_ffff, 1'b1);
    add_len(5, 1'b0);
    add_random(4);
    send_stream();
    drain();
  endtask

  task automatic test_full_key();
    logic [31:0][7:0] kb;
    kb     = random_key();
    kb[5]  = 8'h00;
    kb[31] = 8'hff;
    load_key(6'd32, kb);
    // match with the largest value length, stream ending before the value
    add_len(32, 1'b1);
    add_len(31'h7fff_ffff, 1'b1);
    add_key_name(32, -1);
    send_stream();
    add_len(32, 1'b0);
    add_len(0, 1'b0);
    add_key_name(32, 31);
    send_stream();
    drain();
  endtask

  task automatic test_oversized_key();
    load_key(6'd33, random_key());
    add_len(33, 1'b0);
    add_len(1, 1'b0);
    add_key_name(33, -1);
    add_random(1);
    send_stream();
    drain();
    load_key(6'd63, random_key());
    add_len(63, 1'b0);
    add_len(0, 1'b0);
    add_key_name(63, -1);
    send_stream();
    drain();
  endtask

  task automatic test_long_skip();
    logic [31:0][7:0] kb;
    kb    = random_key();
    kb[0] = 8'h5a;
    load_key(6'd1, kb);
    gaps_on = 1'b0;
    // skip a pair with a long-form value length, then match behind it
    add_len(3, 1'b0);
    add_len(150, 1'b1);
    add_random(153);
    add_len(1, 1'b0);
    add_len(4, 1'b0);
    add_key_name(1, -1);
    add_random(4);
    send_stream();
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_output_stall();
    load_key(6'd0, random_key());
    hold_left = 400;
    repeat (40) begin
      add_len(0, 1'b0);
      add_len(0, 1'b0);
      send_stream();
    end
    drain();
  endtask

  task automatic test_random_streams();
    logic [31:0][7:0] kb;
    logic [5:0]       klen;
    int unsigned      round_start;
    for (int round = 0; round < 8; round++) begin
      kb = random_key();
      case (round)
        0: klen = 6'd0;
        1: begin
          klen = 6'd1;
          kb   = '0;
        end
        2: begin
          klen = 6'd32;
          kb   = '1;
        end
        3: klen = 6'd33;
        4: klen = 6'd63;
        default: klen = 6'($urandom_range(2, 31));
      endcase
      load_key(klen, kb);
      round_start = bytes_sent;
      while (bytes_sent - round_start < ROUND_BYTES) begin
        build_random_stream();
        send_stream();
      end
      drain();
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    stream_if.valid       <= 1'b0;
    stream_if.stream_byte <= '0;
    stream_if.final_byte  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_key();
    test_short_key();
    test_full_key();
    test_oversized_key();
    test_long_skip();
    test_output_stall();
    test_random_streams();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/nvpk_pkg.sv
rtl/core/nvpk_if.sv
rtl/core/nvpk_parse.sv
rtl/core/name_value_pair_key_lookup.sv
verif/name_value_pair_key_lookup_test.sv
